@@ hw/rtl/qws_pkg.sv @@
// Shared types for the sorting FIFO queue: command and status codes,
// controller states, and the command/status bundles between controller and datapath.
// No dependencies.
package qws_pkg;

  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_DUMP = 2'd2,
    CMD_SORT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUMP_RD,
    S_DUMP_EMIT,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_SW,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    ld_out;      // load the output register
    status_t out_status;
    logic    out_from_ram; // item value from read port a, else zero
    logic    out_last;
    logic    push_en;
    logic    pop_en;
    logic    start_walk;  // i = 0, j = 1
    logic    dump_next;   // i = i + 1
    logic    swap_first;  // write slot(i) with entry j, hold entry i
    logic    swap_second; // write slot(j) with held entry i
    logic    advance;     // step to the next sort pair
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
    logic out_free;
    logic dump_last;
    logic less;
    logic pairs_done;
  } ctrl_sts_t;

endpackage

@@ hw/rtl/qws_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module qws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // Write one entry, read two, old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

@@ hw/rtl/qws_ctrl.sv @@
// Controller state machine of the sorting FIFO queue.
// Depends on qws_pkg; drives the datapath through ctrl_cmd_t.
module qws_ctrl import qws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_stall,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  cmd_t   in_cmd;

  assign in_cmd   = cmd_t'(in_command);
  assign in_stall = !((state_r == S_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_DUMP && !sts.empty) begin
            state_nxt = S_DUMP_RD;
          end else if (in_cmd == CMD_SORT && !sts.empty && !sts.single) begin
            state_nxt = S_SORT_RD;
          end
        end
      end
      S_DUMP_RD:   state_nxt = S_DUMP_EMIT;
      S_DUMP_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      S_SORT_RD:   state_nxt = S_SORT_CMP;
      S_SORT_CMP: begin
        if (sts.less) begin
          state_nxt = S_SORT_SW;
        end else begin
          state_nxt = sts.pairs_done ? S_RESP : S_SORT_RD;
        end
      end
      S_SORT_SW:   state_nxt = sts.pairs_done ? S_RESP : S_SORT_RD;
      S_RESP: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.out_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.out_last = 1'b1;
          case (in_cmd)
            CMD_PUSH: begin
              cmd.ld_out     = 1'b1;
              cmd.out_status = sts.full ? ST_FULL : ST_OK;
              cmd.push_en    = !sts.full;
            end
            CMD_POP: begin
              cmd.ld_out     = 1'b1;
              cmd.out_status = sts.empty ? ST_EMPTY : ST_OK;
              cmd.pop_en     = !sts.empty;
            end
            CMD_DUMP: begin
              cmd.ld_out     = sts.empty;
              cmd.out_status = ST_EMPTY;
              cmd.start_walk = !sts.empty;
            end
            CMD_SORT: begin
              cmd.ld_out     = sts.empty || sts.single;
              cmd.out_status = sts.empty ? ST_EMPTY : ST_OK;
              cmd.start_walk = !sts.empty && !sts.single;
            end
            default: begin
              cmd.ld_out = 1'b0;
            end
          endcase
        end
      end
      S_DUMP_EMIT: begin
        if (sts.out_free) begin
          cmd.ld_out       = 1'b1;
          cmd.out_from_ram = 1'b1;
          cmd.out_last     = sts.dump_last;
          cmd.dump_next    = !sts.dump_last;
        end
      end
      S_SORT_CMP: begin
        cmd.swap_first = sts.less;
        cmd.advance    = !sts.less && !sts.pairs_done;
      end
      S_SORT_SW: begin
        cmd.swap_second = 1'b1;
        cmd.advance     = !sts.pairs_done;
      end
      S_RESP: begin
        cmd.ld_out   = sts.out_free;
        cmd.out_last = 1'b1;
      end
      default: begin
        cmd.ld_out = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/qws_dp.sv @@
// Datapath of the sorting FIFO queue: ring pointers, walk indexes, entry RAM,
// compare, and the output register. Depends on qws_pkg and qws_ram.
module qws_dp import qws_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [VAL_W-1:0] in_push_value,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_item_value,
  output logic                    out_last,
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic [VAL_W-1:0] held_r;

  logic             out_valid_r, out_valid_nxt;
  status_t          status_r;
  logic [VAL_W-1:0] value_r;
  logic             last_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [AW-1:0]    slot_i, slot_j;
  logic [VAL_W-1:0] rd_a_data, rd_b_data;
  logic             j_more;

  // Ring slot of an offset from the head: one compare and subtract
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(head) + (CW + 1)'(off);
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign slot_i = slot_of(head_r, i_r);
  assign slot_j = slot_of(head_r, j_r);

  // Select the RAM write
  always_comb begin
    wr_en   = cmd.push_en || cmd.swap_first || cmd.swap_second;
    wr_addr = slot_of(head_r, count_r);
    wr_data = in_push_value;
    if (cmd.swap_first) begin
      wr_addr = slot_i;
      wr_data = rd_b_data;
    end else if (cmd.swap_second) begin
      wr_addr = slot_j;
      wr_data = held_r;
    end
  end

  qws_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (slot_i),
    .rd_a_data (rd_a_data),
    .rd_b_addr (slot_j),
    .rd_b_data (rd_b_data)
  );

  // Status toward the controller
  assign j_more = ((CW + 1)'(j_r) + 1'b1) < (CW + 1)'(count_r);
  always_comb begin
    sts.empty      = (count_r == '0);
    sts.full       = (count_r == CW'(DEPTH));
    sts.single     = (count_r == CW'(1));
    sts.out_free   = !out_valid_r || !out_stall;
    sts.dump_last  = ((CW + 1)'(i_r) + 1'b1) == (CW + 1)'(count_r);
    sts.less       = $signed(rd_b_data) < $signed(rd_a_data);
    sts.pairs_done = !j_more && (((CW + 1)'(i_r) + 2'd2) >= (CW + 1)'(count_r));
  end

  // Advance pointers and walk indexes
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    if (cmd.push_en) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pop_en) begin
      head_nxt  = slot_of(head_r, CW'(1));
      count_nxt = count_r - 1'b1;
    end
    if (cmd.start_walk) begin
      i_nxt = '0;
      j_nxt = CW'(1);
    end
    if (cmd.dump_next) begin
      i_nxt = i_r + 1'b1;
    end
    if (cmd.advance) begin
      if (j_more) begin
        j_nxt = j_r + 1'b1;
      end else begin
        i_nxt = i_r + 1'b1;
        j_nxt = i_r + CW'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
  end

  // Hold entry i across the two swap writes
  always_ff @(posedge clk) begin
    if (cmd.swap_first) begin
      held_r <= rd_a_data;
    end
  end

  // Output register: load a beat, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.ld_out) begin
      status_r <= cmd.out_status;
      value_r  <= cmd.out_from_ram ? rd_a_data : '0;
      last_r   <= cmd.out_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_item_value = $signed(value_r);
  assign out_last       = last_r;

endmodule

@@ hw/rtl/fifo_queue_with_sort.sv @@
// Top level of the sorting FIFO queue: controller plus datapath.
// Depends on qws_pkg, qws_ctrl, qws_dp (and qws_ram below it).
//
// Use: one input channel carries a command (push, pop, dump, sort) and a
// push value; one output channel carries status, item value and a last flag.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// For push and pop, the status beat is in the output register the cycle after
// the command is taken, and the next command is taken then too if the output
// is free. Dump walks the stored entries, each by a RAM read, then an emit;
// an empty dump gives one status beat. Sort is an exchange sort over the
// stored entries with one compare per pair: each pair is read, then compared,
// and a swapped pair adds a write state (two writes on the single RAM write
// port); a status beat follows. The input is stalled while dump or sort runs.
// A stalled output holds its beat; the block then takes no new command, dump
// waits in place, and sort waits before its status beat, until it is taken.
// Reset empties the queue (head and count to zero) and clears the output
// valid; the entry RAM is not cleared and needs no clearing pass.
module fifo_queue_with_sort import qws_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic signed [VAL_W-1:0] in_push_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_item_value,
  output logic                    out_last
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  qws_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  qws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push_value  (in_push_value),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_last       (out_last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

@@ tb/sv/fifo_queue_with_sort_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for fifo_queue_with_sort: a directed table, then random
// command sequences checked against a queue predictor written here.
// Depends on qws_pkg and the fifo_queue_with_sort RTL.
module fifo_queue_with_sort_test;
  import qws_pkg::*;

  localparam int QDEPTH    = 32;
  localparam int HOLD_LONG = 150;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic             last;
  } beat_t;

  typedef struct {
    cmd_t             cmd;
    logic [VAL_W-1:0] val;
    logic             typed;
    status_t          st;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_command = CMD_PUSH;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_item_value;
  logic                    out_last;

  // Queue mirror and expected beats
  logic [VAL_W-1:0] ring [QDEPTH];
  int unsigned      ring_head = 0;
  int unsigned      fill = 0;
  beat_t            step_beats[$];
  beat_t            due_beats[$];

  // Run control and statistics
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int beats_checked = 0;
  int cmd_count [4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int empty_hits = 0;
  int head_wraps = 0;

  // Opening table: empty-queue cases, extremes, single-entry sort, drain to empty
  row_t opening [25] = '{
    '{CMD_POP,  32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_DUMP, 32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_SORT, 32'h0000_0000, 1'b1, ST_EMPTY},
    '{CMD_PUSH, 32'h7fff_ffff, 1'b1, ST_OK},
    '{CMD_SORT, 32'hffff_ffff, 1'b1, ST_OK},
    '{CMD_DUMP, 32'h0000_0000, 1'b0, ST_OK},
    '{CMD_PUSH, 32'h8000_0000, 1'b1, ST_OK},
    '{CMD_PUSH, 32'h0000_0000, 1'b1, ST_OK},
    '{CMD_PUSH, 32'hffff_ffff, 1'b1, ST_OK},
    '{CMD_PUSH, 32'h0000_0001, 1'b1, ST_OK},
    '{CMD_PUSH, 32'h8000_0001, 1'b1, ST_OK},
    '{CMD_DUMP, 32'hffff_ffff, 1'b0, ST_OK},
    '{CMD_SORT, 32'h0000_0000, 1'b1, ST_OK},
    '{CMD_DUMP, 32'h0000_0000, 1'b0, ST_OK},
    '{CMD_POP,  32'hdead_beef, 1'b1, ST_OK},
    '{CMD_PUSH, 32'h7fff_fffe, 1'b1, ST_OK},
    '{CMD_SORT, 32'hffff_ffff, 1'b1, ST_OK},
    '{CMD_DUMP, 32'h5a5a_5a5a, 1'b0, ST_OK},
    '{CMD_POP,  32'h0000_0000, 1'b1, ST_OK},
    '{CMD_POP,  32'hffff_ffff, 1'b1, ST_OK},
    '{CMD_POP,  32'h0000_0000, 1'b1, ST_OK},
    '{CMD_POP,  32'ha5a5_a5a5, 1'b1, ST_OK},
    '{CMD_POP,  32'h0000_0000, 1'b1, ST_OK},
    '{CMD_POP,  32'h0000_0000, 1'b1, ST_OK},
    '{CMD_POP,  32'h7fff_ffff, 1'b1, ST_EMPTY}
  };

  fifo_queue_with_sort #(.DEPTH(QDEPTH)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_last       (out_last)
  );

  always #6 clk = ~clk;

  function automatic int unsigned slot_at(int unsigned offset);
    return (ring_head + offset) % QDEPTH;
  endfunction

  function automatic void queue_beat(status_t st, logic [VAL_W-1:0] val, logic lst);
    beat_t b;
    b.status = st;
    b.value  = val;
    b.last   = lst;
    step_beats.push_back(b);
  endfunction

  // Apply one command to the mirror and collect the beats it should produce
  function automatic void predict_command(cmd_t cmd, logic [VAL_W-1:0] val);
    int unsigned      a;
    int unsigned      b;
    int unsigned      old_head;
    logic [VAL_W-1:0] tmp;
    step_beats.delete();
    case (cmd)
      CMD_PUSH: begin
        if (fill == QDEPTH) begin
          full_hits++;
          queue_beat(ST_FULL, '0, 1'b1);
        end else begin
          ring[slot_at(fill)] = val;
          fill++;
          queue_beat(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP: begin
        if (fill == 0) begin
          empty_hits++;
          queue_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          old_head  = ring_head;
          ring_head = slot_at(1);
          if (ring_head < old_head) head_wraps++;
          fill--;
          queue_beat(ST_OK, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          empty_hits++;
          queue_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (a = 0; a < fill; a++)
            queue_beat(ST_OK, ring[slot_at(a)], a + 1 == fill);
        end
      end
      default: begin
        if (fill == 0) begin
          empty_hits++;
          queue_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          // exchange sort, signed ascending, head to tail
          for (a = 0; a + 1 < fill; a++) begin
            for (b = a + 1; b < fill; b++) begin
              if ($signed(ring[slot_at(b)]) < $signed(ring[slot_at(a)])) begin
                tmp               = ring[slot_at(b)];
                ring[slot_at(b)]  = ring[slot_at(a)];
                ring[slot_at(a)]  = tmp;
              end
            end
          end
          queue_beat(ST_OK, '0, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 50)
      $display("[%0t] MISMATCH beat %0d: %s", $realtime, beats_checked, what);
  endtask

  // Offer one command, hold it until taken, then log its expected beats
  task automatic send_command(cmd_t cmd, logic [VAL_W-1:0] val, logic typed,
                              status_t typed_status);
    beat_t fixed;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(cmd, val);
    if (typed) begin
      fixed.status = typed_status;
      fixed.value  = '0;
      fixed.last   = 1'b1;
      due_beats.push_back(fixed);
    end else begin
      foreach (step_beats[k]) due_beats.push_back(step_beats[k]);
    end
    cmd_count[cmd]++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return {1'b1, {(VAL_W-1){1'b0}}};
      1: return {1'b0, {(VAL_W-1){1'b1}}};
      2, 3: return $urandom_range(7) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 45) return CMD_PUSH;
    if (r < 75) return CMD_POP;
    if (r < 87) return CMD_DUMP;
    return CMD_SORT;
  endfunction

  // Random sequences: fill past full, drain past empty, or a mixed burst
  task automatic run_random(int items);
    int sent;
    int kind;
    int n;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        n = QDEPTH - fill + $urandom_range(2);
        repeat (n) send_command(CMD_PUSH, pick_value(), 1'b0, ST_OK);
        if ($urandom_range(1)) send_command(CMD_SORT, $urandom(), 1'b0, ST_OK);
        send_command(CMD_DUMP, $urandom(), 1'b0, ST_OK);
        n += 2;
      end else if (kind == 2) begin
        n = fill + 1;
        repeat (n) send_command(CMD_POP, $urandom(), 1'b0, ST_OK);
      end else begin
        n = $urandom_range(12, 4);
        repeat (n) send_command(pick_command(), pick_value(), 1'b0, ST_OK);
      end
      sent += n;
    end
  endtask

  // Receiver: random stall, or a long hold-off on request from the sender
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LONG;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Compare each taken result beat with the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d value %0d last %0b",
                                  out_status, out_item_value, out_last));
      end else begin
        want = due_beats.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_item_value !== want.value)
          report_mismatch($sformatf("item_value %0d, want %0d",
                                    out_item_value, $signed(want.value)));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
      end
      beats_checked++;
    end
  end

  // Watchdog
  initial begin
    repeat (2_500_000) @(posedge clk);
    $display("timeout: %0d beats still expected", due_beats.size());
    $display("fifo_queue_with_sort_test failed");
    $finish;
  end

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; sender idles less than half the time, receiver stalls often
    in_idle_pct  = 31;
    out_idle_pct = 68;
    foreach (opening[r])
      send_command(opening[r].cmd, opening[r].val, opening[r].typed, opening[r].st);

    // same idling for the first random stretch
    in_idle_pct  = 31;
    out_idle_pct = 68;
    run_random(135);

    // swap the two sides
    in_idle_pct  = 68;
    out_idle_pct = 31;
    run_random(135);

    // no idling; first back up the block behind a long receiver hold-off
    in_idle_pct  = 0;
    out_idle_pct = 0;
    wait_drained();
    hold_req <= hold_req + 1;
    repeat (QDEPTH + 6) send_command(CMD_PUSH, pick_value(), 1'b0, ST_OK);
    send_command(CMD_SORT, $urandom(), 1'b0, ST_OK);
    send_command(CMD_DUMP, $urandom(), 1'b0, ST_OK);
    wait_drained();
    run_random(85);

    // drain and let the block settle
    in_valid <= 1'b0;
    waited = 0;
    while (due_beats.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    if (due_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", due_beats.size()));
    repeat (20) @(posedge clk);

    $display("commands: %0d push, %0d pop, %0d dump, %0d sort; %0d result beats checked",
             cmd_count[CMD_PUSH], cmd_count[CMD_POP], cmd_count[CMD_DUMP],
             cmd_count[CMD_SORT], beats_checked);
    $display("full rejects %0d, empty statuses %0d, head wraps %0d, mismatches %0d",
             full_hits, empty_hits, head_wraps, mismatches);
    if (mismatches == 0)
      $display("fifo_queue_with_sort_test passed");
    else
      $display("fifo_queue_with_sort_test failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/qws_pkg.sv
hw/rtl/qws_ram.sv
hw/rtl/qws_ctrl.sv
hw/rtl/qws_dp.sv
hw/rtl/fifo_queue_with_sort.sv
tb/sv/fifo_queue_with_sort_test.sv
